// File: sv/rlq_pkg.sv
// ----------------------------------------------------------------------------
// rlq_pkg: shared constants for the reversible linear queue
// Request and status codes, field widths and the default queue depth.
// ----------------------------------------------------------------------------
package rlq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W   = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

// File: sv/rlq_ram.sv
// ----------------------------------------------------------------------------
// rlq_ram: word memory with one write and one registered read port
// Read data shows up one cycle after the read is issued.
// ----------------------------------------------------------------------------
module rlq_ram #(
   parameter int DEPTH = rlq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [rlq_pkg::DATA_W-1:0]     wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [rlq_pkg::DATA_W-1:0]     rd_data
);

   logic [rlq_pkg::DATA_W-1:0] mem [DEPTH];
   logic [rlq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/reversible_linear_queue_top.sv
// ----------------------------------------------------------------------------
// reversible_linear_queue_top: linear queue of signed words with reversal
// Enqueue, dequeue and reverse requests on a non-wrapping queue held in a
// synchronous memory; a second memory serves as scratch stack for reversal.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  request   req_type, req_data_in                         start & !busy
//  response  rsp_data_out, rsp_status, rsp_occupancy       rsp_strobe, 1 cycle
//
//  Enqueue, failed or empty requests: result strobed the cycle after accept,
//  busy stays low. Dequeue: one queue memory read, via ST_DEQ to the response
//  register. Reverse of n words: one word per cycle through the queue memory
//  read port into the stack, then back out of the stack into slots 0..n-1.
//  Reset clears pointers and control; memory contents are never cleared.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module reversible_linear_queue_top #(
   parameter int DEPTH = rlq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rlq_pkg::REQ_W-1:0]           req_type,
   input  logic signed [rlq_pkg::DATA_W-1:0]   req_data_in,
   output logic                                rsp_strobe,
   output logic signed [rlq_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [rlq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rlq_pkg::OCC_W-1:0]           rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEQ   = 3'd1;
   localparam logic [2:0] ST_PUSH  = 3'd2;
   localparam logic [2:0] ST_POPRD = 3'd3;
   localparam logic [2:0] ST_POP   = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [AW-1:0]                    head_ff, head_in;
   logic [AW-1:0]                    tail_ff, tail_in;
   logic                             empty_ff, empty_in;
   logic [AW-1:0]                    cnt_ff, cnt_in;
   logic [AW-1:0]                    last_ff, last_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [rlq_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [rlq_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [rlq_pkg::OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   logic                             accept;
   logic [CW-1:0]                    count_next;

   logic                             q_wr_en, q_rd_en;
   logic [AW-1:0]                    q_wr_addr, q_rd_addr;
   logic [rlq_pkg::DATA_W-1:0]       q_wr_data, q_rd_data;
   logic                             s_wr_en, s_rd_en;
   logic [AW-1:0]                    s_wr_addr, s_rd_addr;
   logic [rlq_pkg::DATA_W-1:0]       s_rd_data;

   rlq_ram #(.DEPTH(DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   rlq_ram #(.DEPTH(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (q_rd_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      q_wr_en       = 1'b0;
      q_wr_addr     = tail_ff;
      q_wr_data     = req_data_in;
      q_rd_en       = 1'b0;
      q_rd_addr     = head_ff;
      s_wr_en       = 1'b0;
      s_wr_addr     = cnt_ff;
      s_rd_en       = 1'b0;
      s_rd_addr     = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in   = '0;
               rsp_status_in = rlq_pkg::STATUS_OK;
               rsp_strobe_in = 1'b1;
               case (req_type)
                  rlq_pkg::REQ_ENQUEUE: begin
                     if (empty_ff) begin
                        head_in   = '0;
                        tail_in   = '0;
                        empty_in  = 1'b0;
                        q_wr_en   = 1'b1;
                        q_wr_addr = '0;
                     end else if (tail_ff == AW'(DEPTH - 1)) begin
                        rsp_status_in = rlq_pkg::STATUS_OVERFLOW;
                     end else begin
                        tail_in   = tail_ff + AW'(1);
                        q_wr_en   = 1'b1;
                        q_wr_addr = tail_ff + AW'(1);
                     end
                  end
                  rlq_pkg::REQ_DEQUEUE: begin
                     if (empty_ff) begin
                        rsp_status_in = rlq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        // hold the beat until the read data returns
                        rsp_strobe_in = 1'b0;
                        q_rd_en       = 1'b1;
                        state_in      = ST_DEQ;
                        if (head_ff == tail_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else begin
                           head_in = head_ff + AW'(1);
                        end
                     end
                  end
                  rlq_pkg::REQ_REVERSE: begin
                     if (!empty_ff) begin
                        rsp_strobe_in = 1'b0;
                        q_rd_en       = 1'b1;
                        cnt_in        = '0;
                        last_in       = tail_ff - head_ff;
                        state_in      = ST_PUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEQ: begin
            rsp_data_in   = q_rd_data;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_PUSH: begin
            // push the word read last cycle, oldest first
            s_wr_en = 1'b1;
            if (cnt_ff == last_ff) begin
               state_in = ST_POPRD;
            end else begin
               q_rd_en   = 1'b1;
               q_rd_addr = head_ff + cnt_ff + AW'(1);
               cnt_in    = cnt_ff + AW'(1);
            end
         end
         ST_POPRD: begin
            s_rd_en   = 1'b1;
            s_rd_addr = last_ff;
            cnt_in    = '0;
            state_in  = ST_POP;
         end
         ST_POP: begin
            // pop newest first into slots from 0 upward
            q_wr_en   = 1'b1;
            q_wr_addr = cnt_ff;
            q_wr_data = s_rd_data;
            if (cnt_ff == last_ff) begin
               head_in       = '0;
               tail_in       = last_ff;
               rsp_data_in   = '0;
               rsp_status_in = rlq_pkg::STATUS_OK;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               s_rd_en   = 1'b1;
               s_rd_addr = last_ff - AW'(1) - cnt_ff;
               cnt_in    = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (empty_in) begin
         count_next = '0;
      end else begin
         count_next = CW'(tail_in - head_in) + CW'(1);
      end
      rsp_occ_in = rlq_pkg::OCC_W'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         cnt_ff        <= '0;
         last_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         cnt_ff        <= cnt_in;
         last_ff       <= last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_empty_ptrs_zero: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with nonzero pointers");

   a_tail_not_below_head: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> tail_ff >= head_ff)
      else $error("tail slot below head slot");

   a_busy_end_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a response beat");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != rlq_pkg::STATUS_OK) |-> rsp_data_out == '0)
      else $error("nonzero data on an error response");

endmodule
